@@ rtl/sorted_priority_queue_assert.svh @@
// Assertion macros for the sorted priority queue sequencer.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the cycle after.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// Types, codes and sizes shared by the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int MAX_RUN = 16;
  localparam int RUN_CAP = (MAX_RUN < DEPTH) ? MAX_RUN : DEPTH;
  localparam int STEP_W  = $clog2(DEPTH);
  localparam int CNT_W   = 5;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [3:0] URG_HIGH   = 4'd1;
  localparam logic [3:0] URG_MEDIUM = 4'd2;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_POP     = 3'd1,
    ACT_VIEW    = 3'd2,
    ACT_DISPLAY = 3'd3,
    ACT_COUNT   = 3'd4,
    ACT_SEARCH  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] parcel_id;
    logic [15:0] sender_tag;
    logic [15:0] receiver_tag;
    logic [31:0] weight_bits;
    logic [3:0]  urgency;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      entry_id;
    logic [15:0]      entry_sender;
    logic [15:0]      entry_receiver;
    logic [31:0]      entry_weight;
    logic [3:0]       entry_urgency;
    logic [CNT_W-1:0] count_high;
    logic [CNT_W-1:0] count_medium;
    logic [CNT_W-1:0] count_low;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] sender;
    logic [15:0] receiver;
    logic [31:0] weight;
    logic [3:0]  urgency;
  } entry_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctl_t;

  // What the sequencer sees of the chain.
  typedef struct packed {
    logic   head_valid;
    logic   second_valid;
    logic   full;
    entry_t head;
  } chain_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue: top level with the cell chain and the sequencer.
//
// Usage: one action per input beat on in_valid/in_ready/in_data; results
// leave on out_valid/out_ready/out_data, one beat each, the final one of an
// action marked by last_of_run. Actions 6 and 7 are taken and dropped.
// Entries sit in a chain of DEPTH cells kept sorted by (urgency, id), head
// in cell 0. Insert, dispatch and view finish in the accept cycle and their
// result is registered the cycle after, so such actions run at one per
// cycle while the receiver keeps up. Display, count and search rotate the
// chain once through the head cell, one slot per cycle while the receiver
// keeps up, and no new action is taken until the rotation is done; the
// rotation leaves the order unchanged. On an empty queue these answer at
// once with an empty status.
// A single output register holds each beat; while the receiver stalls, the
// sequencer stops and no new action is taken. Reset empties the queue and
// the output register.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cell_ctl_t   ctl;
  chain_stat_t stat;

  logic   cell_valid [DEPTH];
  entry_t cell_entry [DEPTH];
  logic   cell_after [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic   p_valid, p_after, n_valid;
      entry_t p_entry, n_entry;

      if (gi == 0) begin : g_head
        assign p_valid = 1'b0;
        assign p_entry = '0;
        assign p_after = 1'b1;
      end else begin : g_body
        assign p_valid = cell_valid[gi-1];
        assign p_entry = cell_entry[gi-1];
        assign p_after = cell_after[gi-1];
      end

      // The tail refills from the head only while rotating; a dispatch empties it.
      if (gi == DEPTH - 1) begin : g_tail
        assign n_valid = cell_valid[0] && (ctl.op == CELL_ROTATE);
        assign n_entry = cell_entry[0];
      end else begin : g_link
        assign n_valid = cell_valid[gi+1];
        assign n_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_valid (p_valid),
        .prev_entry (p_entry),
        .prev_after (p_after),
        .next_valid (n_valid),
        .next_entry (n_entry),
        .valid      (cell_valid[gi]),
        .entry      (cell_entry[gi]),
        .after      (cell_after[gi])
      );
    end
  endgenerate

  assign stat.head_valid   = cell_valid[0];
  assign stat.second_valid = cell_valid[1];
  assign stat.full         = cell_valid[DEPTH-1];
  assign stat.head         = cell_entry[0];

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat),
    .ctl       (ctl)
  );

endmodule

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      prev_valid,
  input  entry_t    prev_entry,
  input  logic      prev_after,
  input  logic      next_valid,
  input  entry_t    next_entry,
  output logic      valid,
  output entry_t    entry,
  output logic      after
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;

  // An entry stays ahead of a new one whose key is greater than or equal to its own.
  assign after = valid_r &&
      ({entry_r.urgency, entry_r.id} <= {ctl.new_entry.urgency, ctl.new_entry.id});

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (!after) begin
          if (prev_after) begin
            valid_nxt = 1'b1;
            entry_nxt = ctl.new_entry;
          end else begin
            valid_nxt = prev_valid;
            entry_nxt = prev_entry;
          end
        end
      end
      CELL_POP, CELL_ROTATE: begin
        valid_nxt = next_valid;
        entry_nxt = next_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

@@ rtl/spq_ctrl.sv @@
// Sequencer: decodes actions, drives the cell chain and holds the output register.
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_ctrl import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  chain_stat_t stat,
  output cell_ctl_t   ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [15:0]       key_r, key_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt, med_r, med_nxt, lo_r, lo_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic      step_go, in_fire, emit, last_step, match;
  out_item_t res;

  // A step may run only when the output register can take a beat.
  assign step_go   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && step_go;
  assign in_fire   = in_valid && in_ready;
  assign last_step = (step_r == STEP_W'(DEPTH - 1));
  assign match     = stat.head_valid && (stat.head.id == key_r) && !found_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    step_nxt  = step_r;
    hi_nxt    = hi_r;
    med_nxt   = med_r;
    lo_nxt    = lo_r;
    found_nxt = found_r;
    emit      = 1'b0;
    res       = '0;
    ctl.op    = CELL_HOLD;
    ctl.new_entry.id       = in_data.parcel_id;
    ctl.new_entry.sender   = in_data.sender_tag;
    ctl.new_entry.receiver = in_data.receiver_tag;
    ctl.new_entry.weight   = in_data.weight_bits;
    ctl.new_entry.urgency  = in_data.urgency;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res.last_of_run = 1'b1;
          unique case (action_t'(in_data.action))
            ACT_INSERT: begin
              emit = 1'b1;
              if (stat.full) begin
                res.status = STAT_FULL;
              end else begin
                res.status = STAT_OK;
                ctl.op     = CELL_INSERT;
              end
            end
            ACT_POP, ACT_VIEW: begin
              emit = 1'b1;
              if (!stat.head_valid) begin
                res.status = STAT_EMPTY;
              end else begin
                res.status         = STAT_OK;
                res.entry_id       = stat.head.id;
                res.entry_sender   = stat.head.sender;
                res.entry_receiver = stat.head.receiver;
                res.entry_weight   = stat.head.weight;
                res.entry_urgency  = stat.head.urgency;
                if (action_t'(in_data.action) == ACT_POP) begin
                  ctl.op = CELL_POP;
                end
              end
            end
            ACT_DISPLAY, ACT_COUNT, ACT_SEARCH: begin
              if (!stat.head_valid) begin
                emit       = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                state_nxt = ST_SCAN;
                act_nxt   = action_t'(in_data.action);
                key_nxt   = in_data.parcel_id;
                step_nxt  = '0;
                hi_nxt    = '0;
                med_nxt   = '0;
                lo_nxt    = '0;
                found_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // One full rotation of the chain walks every slot past the head and
        // leaves the queue as it was.
        if (step_go) begin
          ctl.op   = CELL_ROTATE;
          step_nxt = step_r + STEP_W'(1);
          res.status         = STAT_OK;
          res.entry_id       = stat.head.id;
          res.entry_sender   = stat.head.sender;
          res.entry_receiver = stat.head.receiver;
          res.entry_weight   = stat.head.weight;
          res.entry_urgency  = stat.head.urgency;
          unique case (act_r)
            ACT_DISPLAY: begin
              emit = stat.head_valid && (step_r <= STEP_W'(RUN_CAP - 1));
              res.last_of_run = !stat.second_valid || (step_r == STEP_W'(RUN_CAP - 1));
            end
            ACT_COUNT: begin
              if (stat.head_valid) begin
                if (stat.head.urgency == URG_HIGH) begin
                  hi_nxt = sat_inc(hi_r);
                end else if (stat.head.urgency == URG_MEDIUM) begin
                  med_nxt = sat_inc(med_r);
                end else begin
                  lo_nxt = sat_inc(lo_r);
                end
              end
              res                = '0;
              res.status         = STAT_OK;
              res.count_high     = hi_nxt;
              res.count_medium   = med_nxt;
              res.count_low      = lo_nxt;
              res.last_of_run    = 1'b1;
              emit               = last_step;
            end
            ACT_SEARCH: begin
              res.last_of_run = 1'b1;
              if (match) begin
                emit      = 1'b1;
                found_nxt = 1'b1;
              end else if (last_step && !found_r) begin
                emit            = 1'b1;
                res             = '0;
                res.status      = STAT_NOT_FOUND;
                res.last_of_run = 1'b1;
              end
            end
            default: ;
          endcase
          if (last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit) begin
      out_r <= res;
    end
    act_r   <= act_nxt;
    key_r   <= key_nxt;
    step_r  <= step_nxt;
    hi_r    <= hi_nxt;
    med_r   <= med_nxt;
    lo_r    <= lo_nxt;
    found_r <= found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SPQ_ASSERT_NEXT(a_pop_returns_head,
      in_fire && (in_data.action == ACT_POP) && stat.head_valid,
      out_valid_r && out_r.last_of_run && (out_r.status == STAT_OK),
      "dispatch on a filled queue did not return a final ok beat")
  `SPQ_ASSERT_NEXT(a_full_insert_rejected,
      in_fire && (in_data.action == ACT_INSERT) && stat.full,
      out_valid_r && (out_r.status == STAT_FULL),
      "insert into a full queue was not rejected")
  `SPQ_ASSERT_SAME(a_run_continues,
      out_valid_r && !out_r.last_of_run,
      state_r == ST_SCAN,
      "a beat that is not the last of its run was left without a scan")
  `SPQ_ASSERT_SAME(a_single_search_hit,
      (state_r == ST_SCAN) && (act_r == ACT_SEARCH) && found_r,
      !emit,
      "search produced a second result")

endmodule

@@ tb/sorted_priority_queue_test.sv @@
// Self-checking testbench for the sorted priority queue with a built-in predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 4 * DEPTH;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  // Action codes that the block takes and drops.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  sorted_priority_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted queue contents, head at index 0.
  entry_t slots [DEPTH];
  int     fill = 0;

  in_item_t  pending_items [$];
  int        pending_gaps [$];
  out_item_t expected_beats [$];

  int items_queued = 0;
  int items_taken = 0;
  int beats_checked = 0;
  int failures = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int rx_mode_left = 0;
  bit rx_calm = 1'b0;

  int peak_fill = 0;
  int full_rejects = 0;
  int empty_answers = 0;
  int failed_searches = 0;
  int longest_run = 0;

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic out_item_t status_beat(status_t st);
    out_item_t b;
    b = '0;
    b.status = st;
    b.last_of_run = 1'b1;
    return b;
  endfunction

  function automatic out_item_t entry_beat(entry_t e, logic last);
    out_item_t b;
    b = '0;
    b.status = STAT_OK;
    b.entry_id = e.id;
    b.entry_sender = e.sender;
    b.entry_receiver = e.receiver;
    b.entry_weight = e.weight;
    b.entry_urgency = e.urgency;
    b.last_of_run = last;
    return b;
  endfunction

  // Updates the predicted queue for one accepted action and records its results.
  task automatic apply_action(input in_item_t it);
    entry_t           e;
    out_item_t        b;
    int               pos;
    int               run;
    bit               hit;
    logic [CNT_W-1:0] n_hi, n_med, n_lo;
    if (it.action == ACT_SPARE_LO || it.action == ACT_SPARE_HI) return;
    if (it.action == ACT_INSERT) begin
      if (fill >= DEPTH) begin
        expected_beats.push_back(status_beat(STAT_FULL));
        full_rejects++;
        return;
      end
      e.id = it.parcel_id;
      e.sender = it.sender_tag;
      e.receiver = it.receiver_tag;
      e.weight = it.weight_bits;
      e.urgency = it.urgency;
      // Equal keys go behind the ones already held.
      pos = 0;
      while (pos < fill && (slots[pos].urgency < e.urgency ||
             (slots[pos].urgency == e.urgency && slots[pos].id <= e.id)))
        pos++;
      for (int k = fill; k > pos; k--) slots[k] = slots[k - 1];
      slots[pos] = e;
      fill++;
      if (fill > peak_fill) peak_fill = fill;
      expected_beats.push_back(status_beat(STAT_OK));
      return;
    end
    if (fill == 0) begin
      expected_beats.push_back(status_beat(STAT_EMPTY));
      empty_answers++;
      return;
    end
    case (it.action)
      ACT_POP, ACT_VIEW: begin
        expected_beats.push_back(entry_beat(slots[0], 1'b1));
        if (it.action == ACT_POP) begin
          for (int k = 0; k + 1 < fill; k++) slots[k] = slots[k + 1];
          fill--;
        end
      end
      ACT_DISPLAY: begin
        run = (fill < RUN_CAP) ? fill : RUN_CAP;
        for (int k = 0; k < run; k++)
          expected_beats.push_back(entry_beat(slots[k], k + 1 == run));
        if (run > longest_run) longest_run = run;
      end
      ACT_COUNT: begin
        n_hi = '0;
        n_med = '0;
        n_lo = '0;
        for (int k = 0; k < fill; k++) begin
          if (slots[k].urgency == URG_HIGH) begin
            if (n_hi != CNT_MAX) n_hi++;
          end else if (slots[k].urgency == URG_MEDIUM) begin
            if (n_med != CNT_MAX) n_med++;
          end else begin
            if (n_lo != CNT_MAX) n_lo++;
          end
        end
        b = status_beat(STAT_OK);
        b.count_high = n_hi;
        b.count_medium = n_med;
        b.count_low = n_lo;
        expected_beats.push_back(b);
      end
      default: begin
        hit = 1'b0;
        for (int k = 0; k < fill && !hit; k++) begin
          if (slots[k].id == it.parcel_id) begin
            expected_beats.push_back(entry_beat(slots[k], 1'b1));
            hit = 1'b1;
          end
        end
        if (!hit) begin
          expected_beats.push_back(status_beat(STAT_NOT_FOUND));
          failed_searches++;
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      failures++;
    end
  endtask

  task automatic compare_beat(input out_item_t want, got);
    check_field("status", want.status, got.status);
    check_field("entry_id", want.entry_id, got.entry_id);
    check_field("entry_sender", want.entry_sender, got.entry_sender);
    check_field("entry_receiver", want.entry_receiver, got.entry_receiver);
    check_field("entry_weight", want.entry_weight, got.entry_weight);
    check_field("entry_urgency", want.entry_urgency, got.entry_urgency);
    check_field("count_high", want.count_high, got.count_high);
    check_field("count_medium", want.count_medium, got.count_medium);
    check_field("count_low", want.count_low, got.count_low);
    check_field("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  function automatic in_item_t build_item(logic [2:0] act, logic [15:0] id,
                                          logic [15:0] snd, logic [15:0] rcv,
                                          logic [31:0] wgt, logic [3:0] urg);
    in_item_t it;
    it.action = act;
    it.parcel_id = id;
    it.sender_tag = snd;
    it.receiver_tag = rcv;
    it.weight_bits = wgt;
    it.urgency = urg;
    return it;
  endfunction

  task automatic queue_item(input in_item_t it, input int gap);
    pending_items.push_back(it);
    pending_gaps.push_back(gap);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_beats.size() != 0)
      @(negedge clk);
  endtask

  // Sender: one beat held until taken, then the gap that came with it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_action(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0 || pending_items.size() == 0) begin
          if (tx_wait > 0) tx_wait--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_items.pop_front();
          tx_wait = pending_gaps.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each beat and stalls at random, with calm stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: 0x%0h", out_data);
          failures++;
        end else begin
          compare_beat(expected_beats.pop_front(), out_data);
        end
        beats_checked++;
      end
      if (rx_mode_left == 0) begin
        rx_calm = ($urandom_range(0, 2) == 0);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_wait = rx_calm ? 0 : idle_len();
      end
    end
  end

  initial begin
    logic [15:0] id_pool [6];
    int          made;
    int          seg_left;
    int          bias;
    int          phase;
    int          r;
    bit          tx_calm;
    logic [2:0]  act;
    logic [15:0] id;
    logic [3:0]  urg;

    // Dispatch, display, count and search on an empty queue, and a dropped action code.
    queue_item(build_item(ACT_POP, '0, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_DISPLAY, '0, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_COUNT, '0, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_SEARCH, 16'hFFFF, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_SPARE_LO, '1, '1, '1, '1, '1), idle_len());
    // Fill to the brim with extreme values and repeated keys.
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: queue_item(build_item(ACT_INSERT, '0, '0, '0, '0, 4'd0), 0);
        1: queue_item(build_item(ACT_INSERT, '1, '1, '1, '1, 4'd15), 0);
        default: begin
          urg = (i % 3 == 0) ? URG_HIGH : (i % 3 == 1) ? URG_MEDIUM : 4'($urandom);
          queue_item(build_item(ACT_INSERT, 16'(i % 5), 16'($urandom), 16'($urandom),
                                $urandom, urg), idle_len());
        end
      endcase
    end
    queue_item(build_item(ACT_INSERT, 16'h0007, '1, '0, '1, 4'd0), idle_len());
    queue_item(build_item(ACT_DISPLAY, '0, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_COUNT, '0, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_SEARCH, 16'hFFFF, '0, '0, '0, '0), idle_len());
    queue_item(build_item(ACT_SEARCH, 16'h8000, '0, '0, '0, '0), idle_len());

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Let the directed part drain completely before the random part.
    wait_idle();

    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    // Segments alternate between filling, draining and a mix, so the queue
    // swings between empty and full.
    made = 0;
    seg_left = 0;
    phase = 0;
    bias = 50;
    tx_calm = 1'b0;
    while (made < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        phase = (phase + 1) % 3;
        bias = (phase == 0) ? 50 : (phase == 1) ? 80 : 15;
        seg_left = $urandom_range(12, 30);
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < bias) begin
        act = ACT_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) act = ACT_POP;
        else if (r < 50) act = ACT_VIEW;
        else if (r < 62) act = ACT_DISPLAY;
        else if (r < 72) act = ACT_COUNT;
        else if (r < 95) act = ACT_SEARCH;
        else act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end
      // Pooled ids give duplicate keys and search hits.
      id = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 5)] : 16'($urandom);
      urg = ($urandom_range(0, 99) < 40) ? ($urandom_range(0, 1) ? URG_HIGH : URG_MEDIUM)
                                         : 4'($urandom);
      queue_item(build_item(act, id, 16'($urandom), 16'($urandom), $urandom, urg),
                 tx_calm ? 0 : idle_len());
      if (act != ACT_SPARE_LO && act != ACT_SPARE_HI) made++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Checked %0d result beats from %0d actions; queue peaked at %0d of %0d entries.",
             beats_checked, items_taken, peak_fill, DEPTH);
    $display("Full rejects %0d, empty answers %0d, failed searches %0d, longest display %0d.",
             full_rejects, empty_answers, failed_searches, longest_run);
    if (failures == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d result beats outstanding.", expected_beats.size());
    $display("simulation failed");
    $finish;
  end

endmodule
